>>> rtl/tthe_pkg.sv
// Package for the text to HTML escaper: output token codes, job record,
// register indexes and the string table used by the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tthe_pkg;

    localparam int TabStopDefault = 8;
    localparam int MaxTabStop     = 16;
    localparam int RepW           = $clog2(MaxTabStop + 1);
    localparam int MaxResults     = 64;
    localparam int CntW           = $clog2(MaxResults);
    localparam int QueueDepth     = 4;
    localparam int NumSlots       = 4;
    localparam int SlotW          = $clog2(NumSlots);
    localparam int CfgIndexW      = 3;

    localparam int SlotPre    = 0;
    localparam int SlotSpace  = 1;
    localparam int SlotPrefix = 2;
    localparam int SlotBody   = 3;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_CONVERT_SPACES      = 3'd0,
        CFG_PRESERVE_HIGH_BYTES = 3'd1,
        CFG_QUESTION_HIGH_BYTES = 3'd2,
        CFG_QUOTE_PREFIX        = 3'd3,
        CFG_NEWLINE_BREAK       = 3'd4,
        CFG_WRAP_PRE            = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic convert_spaces;
        logic preserve_high_bytes;
        logic question_high_bytes;
        logic quote_prefix;
        logic newline_break;
        logic wrap_pre;
    } cfg_t;

    typedef enum logic [3:0] {
        TOK_NONE,
        TOK_PRE_START,
        TOK_PRE_CLOSE,
        TOK_SPACE,
        TOK_NBSP,
        TOK_PREFIX,
        TOK_LT,
        TOK_GT,
        TOK_AMP,
        TOK_QUOT,
        TOK_BR_NL,
        TOK_BYTE,
        TOK_DEC
    } tok_t;

    typedef struct packed {
        tok_t [NumSlots-1:0] tok;
        logic [7:0]          data;
        logic [3:0]          dig2;
        logic [3:0]          dig1;
        logic [3:0]          dig0;
        logic [1:0]          ndig;
        logic [RepW-1:0]     reps;
    } job_t;

    typedef struct packed {
        logic             found;
        logic [SlotW-1:0] idx;
    } slot_sel_t;

    function automatic logic [47:0] tok_str(input tok_t tok);
        logic [47:0] s;
        begin
            s = '0;
            unique case (tok)
                TOK_PRE_START: s = 48'("<pre>");
                TOK_PRE_CLOSE: s = 48'("</pre>");
                TOK_SPACE:     s = 48'(" ");
                TOK_NBSP:      s = 48'("&nbsp;");
                TOK_PREFIX:    s = 48'("&gt; ");
                TOK_LT:        s = 48'("&lt;");
                TOK_GT:        s = 48'("&gt;");
                TOK_AMP:       s = 48'("&amp;");
                TOK_QUOT:      s = 48'("&quot;");
                TOK_BR_NL:     s = {8'h00, 32'("<br>"), 8'h0A};
                default:       s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [2:0] tok_len(input tok_t tok, input logic [1:0] ndig);
        logic [2:0] n;
        begin
            unique case (tok)
                TOK_PRE_START: n = 3'd5;
                TOK_PRE_CLOSE: n = 3'd6;
                TOK_NBSP:      n = 3'd6;
                TOK_PREFIX:    n = 3'd5;
                TOK_LT:        n = 3'd4;
                TOK_GT:        n = 3'd4;
                TOK_AMP:       n = 3'd5;
                TOK_QUOT:      n = 3'd6;
                TOK_BR_NL:     n = 3'd5;
                TOK_DEC:       n = 3'd3 + {1'b0, ndig};
                default:       n = 3'd1;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] tok_char(input tok_t tok, input logic [2:0] idx,
                                            input job_t job);
        logic [2:0]  len;
        logic [5:0]  sh;
        logic [47:0] s;
        logic [2:0]  k;
        logic [3:0]  d;
        logic [7:0]  c;
        begin
            len = tok_len(tok, job.ndig);
            sh  = {len - 3'd1 - idx, 3'b000};
            s   = tok_str(tok) >> sh;
            k   = idx - 3'd2 + (3'd3 - {1'b0, job.ndig});
            unique case (k)
                3'd0:    d = job.dig2;
                3'd1:    d = job.dig1;
                default: d = job.dig0;
            endcase
            if (tok == TOK_BYTE)
            begin
                c = job.data;
            end
            else if (tok == TOK_DEC)
            begin
                if (idx == 3'd0)
                begin
                    c = 8'h26;
                end
                else if (idx == 3'd1)
                begin
                    c = 8'h23;
                end
                else if (idx == len - 3'd1)
                begin
                    c = 8'h3B;
                end
                else
                begin
                    c = 8'h30 + {4'b0000, d};
                end
            end
            else
            begin
                c = s[7:0];
            end
            return c;
        end
    endfunction

    function automatic slot_sel_t next_slot(input tok_t [NumSlots-1:0] tok,
                                            input logic [SlotW:0] start);
        slot_sel_t r;
        begin
            r = '0;
            for (int k = NumSlots - 1; k >= 0; k--)
            begin
                if (k >= int'(start) && tok[k] != TOK_NONE)
                begin
                    r.found = 1'b1;
                    r.idx   = SlotW'(k);
                end
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/text_to_html_escaper_unit.sv
// Top level of the text to HTML escaper: configuration registers and the
// front part, job queue and back part. Depends on tthe_pkg, tthe_front,
// tthe_queue and tthe_back.
//
// Input channel: in_valid / in_stall carry text_byte and flush, one item per
// accepted cycle. Output channel: out_valid / out_stall carry out_char and
// last, one byte per accepted cycle; last marks the final byte of an item.
// Configuration: write cfg_data into register cfg_index when cfg_we is high,
// only while the block is idle.
// The first byte of an item passes through the job queue and the current job
// register before it reaches the output register. The back part serializes one
// byte per cycle while out_stall does not hold it, and an item gives at most 64
// bytes; items giving one byte likewise stream at one per cycle. A held space
// (convert_spaces set, not at line start) gives no byte of its own. The front takes
// items while the four-entry job queue has room; in_stall is high while it is full.
// Reset: the configuration registers clear to 0, the block is at line start
// with no space held, no pre tag open, and the queue and output register are empty.
// When out_stall is high the output register holds its byte, the back part
// halts, the queue fills and then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module text_to_html_escaper_unit #(
    parameter int TAB_STOP = tthe_pkg::TabStopDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tthe_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic                          cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    text_byte,
    input  wire logic                          flush,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_char,
    output logic                               last
);
    import tthe_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    job_t push_job;
    job_t q_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CONVERT_SPACES:      cfg_next.convert_spaces      = cfg_data;
                CFG_PRESERVE_HIGH_BYTES: cfg_next.preserve_high_bytes = cfg_data;
                CFG_QUESTION_HIGH_BYTES: cfg_next.question_high_bytes = cfg_data;
                CFG_QUOTE_PREFIX:        cfg_next.quote_prefix        = cfg_data;
                CFG_NEWLINE_BREAK:       cfg_next.newline_break       = cfg_data;
                CFG_WRAP_PRE:            cfg_next.wrap_pre            = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tthe_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .flush     (flush),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_full    (q_full)
    );

    tthe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    tthe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> rtl/tthe_front.sv
// Front part of the escaper: accepts text items, classifies each byte,
// keeps line and column state and writes a job record per item with output.
// Depends on tthe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthe_front #(
    parameter int TAB_STOP = tthe_pkg::TabStopDefault
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tthe_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    text_byte,
    input  wire logic          flush,
    output logic               q_push,
    output tthe_pkg::job_t     q_job,
    input  wire logic          q_full
);
    import tthe_pkg::*;

    localparam int ColW = $clog2(TAB_STOP);
    localparam logic [ColW-1:0] PrefixPhase = ColW'(2 % TAB_STOP);
    localparam logic [ColW-1:0] LastPhase   = ColW'(TAB_STOP - 1);

    logic [ColW-1:0] column_reg, column_next;
    logic            line_start_reg, line_start_next;
    logic            pending_reg, pending_next;
    logic            pre_tag_reg, pre_tag_next;

    logic            accept;
    logic            pre_now;
    logic            is_sp;
    logic            job_empty;
    logic [ColW-1:0] p0, p1;
    logic [7:0]      rem;
    logic [14:0]     prod;
    logic [3:0]      tens;
    logic [7:0]      ones;
    logic [1:0]      hund;
    job_t            job;

    function automatic logic [ColW-1:0] adv(input logic [ColW-1:0] p);
        return (p == LastPhase) ? '0 : p + 1'b1;
    endfunction

    // decimal digits of the byte
    always_comb
    begin
        if (text_byte >= 8'd200)
        begin
            hund = 2'd2;
            rem  = text_byte - 8'd200;
        end
        else if (text_byte >= 8'd100)
        begin
            hund = 2'd1;
            rem  = text_byte - 8'd100;
        end
        else
        begin
            hund = 2'd0;
            rem  = text_byte;
        end
        prod = 15'(rem[6:0]) * 15'd205;
        tens = prod[14:11];
        ones = rem - ({4'b0000, tens} << 3) - ({4'b0000, tens} << 1);
    end

    always_comb
    begin
        job          = '0;
        job.tok      = {NumSlots{TOK_NONE}};
        job.reps     = RepW'(1);
        job.data     = text_byte;
        job.dig2     = {2'b00, hund};
        job.dig1     = tens;
        job.dig0     = ones[3:0];
        job.ndig     = (text_byte >= 8'd100) ? 2'd3 : (text_byte >= 8'd10) ? 2'd2 : 2'd1;
        column_next     = column_reg;
        line_start_next = line_start_reg;
        pending_next    = pending_reg;
        pre_now         = pre_tag_reg;
        is_sp           = (text_byte == 8'h20) || (text_byte == 8'h09);

        if (cfg.wrap_pre && !pre_tag_reg)
        begin
            job.tok[SlotPre] = TOK_PRE_START;
            pre_now          = 1'b1;
        end
        pre_tag_next = pre_now;

        if (line_start_reg)
        begin
            p0 = cfg.quote_prefix ? PrefixPhase : '0;
        end
        else
        begin
            p0 = column_reg;
        end
        p1 = pending_reg ? adv(p0) : p0;

        if (flush)
        begin
            if (pending_reg)
            begin
                job.tok[SlotSpace] = TOK_SPACE;
            end
            if (pre_now)
            begin
                job.tok[SlotBody] = TOK_PRE_CLOSE;
            end
            column_next     = '0;
            line_start_next = 1'b1;
            pending_next    = 1'b0;
            pre_tag_next    = 1'b0;
        end
        else if (text_byte == 8'h0A)
        begin
            if (pending_reg)
            begin
                job.tok[SlotSpace] = TOK_SPACE;
            end
            if (line_start_reg && cfg.quote_prefix)
            begin
                job.tok[SlotPrefix] = TOK_PREFIX;
            end
            job.tok[SlotBody] = cfg.newline_break ? TOK_BR_NL : TOK_BYTE;
            column_next     = '0;
            line_start_next = 1'b1;
            pending_next    = 1'b0;
        end
        else
        begin
            if (line_start_reg && cfg.quote_prefix)
            begin
                job.tok[SlotPrefix] = TOK_PREFIX;
            end
            if (pending_reg)
            begin
                job.tok[SlotSpace] = is_sp ? TOK_NBSP : TOK_SPACE;
            end
            line_start_next = 1'b0;
            pending_next    = 1'b0;
            column_next     = adv(p1);
            priority if (text_byte == 8'h3C)
            begin
                job.tok[SlotBody] = TOK_LT;
            end
            else if (text_byte == 8'h3E)
            begin
                job.tok[SlotBody] = TOK_GT;
            end
            else if (text_byte == 8'h26)
            begin
                job.tok[SlotBody] = TOK_AMP;
            end
            else if (text_byte == 8'h22)
            begin
                job.tok[SlotBody] = TOK_QUOT;
            end
            else if (text_byte == 8'h09 && cfg.convert_spaces)
            begin
                job.tok[SlotBody] = TOK_NBSP;
                job.reps          = RepW'(TAB_STOP) - RepW'(p1);
                column_next       = '0;
            end
            else if (text_byte == 8'h20 && cfg.convert_spaces)
            begin
                if (line_start_reg)
                begin
                    job.tok[SlotBody] = TOK_NBSP;
                end
                else
                begin
                    pending_next = 1'b1;
                    column_next  = p1;
                end
            end
            else if ((text_byte < 8'h20 || text_byte >= 8'h80) && !cfg.preserve_high_bytes)
            begin
                if (cfg.question_high_bytes)
                begin
                    job.tok[SlotBody] = TOK_BYTE;
                    job.data          = 8'h3F;
                end
                else
                begin
                    job.tok[SlotBody] = TOK_DEC;
                end
            end
            else
            begin
                job.tok[SlotBody] = TOK_BYTE;
            end
        end
    end

    assign job_empty = (job.tok == {NumSlots{TOK_NONE}});
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign q_push    = accept && !job_empty;
    assign q_job     = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            line_start_reg <= 1'b1;
            pending_reg    <= 1'b0;
            pre_tag_reg    <= 1'b0;
        end
        else if (accept)
        begin
            column_reg     <= column_next;
            line_start_reg <= line_start_next;
            pending_reg    <= pending_next;
            pre_tag_reg    <= pre_tag_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tthe_queue.sv
// Short job queue between the front and back parts of the escaper.
// Depends on tthe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthe_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tthe_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output tthe_pkg::job_t      q_job
);
    import tthe_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntQW = $clog2(QueueDepth + 1);

    job_t             entry_reg [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntQW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full    = (count_reg == CntQW'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full job queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid) else $error("pop from empty job queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntQW'(QueueDepth)) else $error("job queue count overrun");

endmodule

`default_nettype wire

>>> rtl/tthe_back.sv
// Back part of the escaper: walks each job record token by token and
// drives one output byte per cycle through a registered output stage while
// out_stall does not hold it. Depends on tthe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire tthe_pkg::job_t q_job,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_char,
    output logic                last
);
    import tthe_pkg::*;

    logic             cur_valid_reg, cur_valid_next;
    job_t             cur_job_reg, cur_job_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic [2:0]       idx_reg, idx_next;
    logic [RepW-1:0]  rep_reg, rep_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             last_reg, last_next;

    logic      advance;
    logic      emit;
    logic      load;
    tok_t      tok_cur;
    logic [2:0] len;
    logic      end_tok;
    logic      end_slot;
    logic      job_done;
    slot_sel_t later;
    slot_sel_t first;

    always_comb
    begin
        advance  = !out_valid_reg || !out_stall;
        emit     = cur_valid_reg && advance;
        tok_cur  = cur_job_reg.tok[slot_reg];
        len      = tok_len(tok_cur, cur_job_reg.ndig);
        end_tok  = (idx_reg == len - 3'd1);
        end_slot = end_tok && ((slot_reg != SlotW'(SlotBody)) || (rep_reg <= RepW'(1)));
        later    = next_slot(cur_job_reg.tok, {1'b0, slot_reg} + 1'b1);
        first    = next_slot(q_job.tok, '0);
        job_done = (end_slot && !later.found) || (cnt_reg == CntW'(MaxResults - 1));
        load     = (!cur_valid_reg || (emit && job_done)) && q_valid;

        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        cnt_next       = cnt_reg;

        if (load) begin
            cur_valid_next = 1'b1;
            cur_job_next   = q_job;
            slot_next      = first.idx;
            idx_next       = '0;
            rep_next       = q_job.reps;
            cnt_next       = '0;
        end
        else if (emit && job_done) begin
            cur_valid_next = 1'b0;
        end
        else if (emit) begin
            cnt_next = cnt_reg + 1'b1;
            if (!end_tok) begin
                idx_next = idx_reg + 1'b1;
            end
            else if (!end_slot) begin
                idx_next = '0;
                rep_next = rep_reg - 1'b1;
            end
            else begin
                idx_next  = '0;
                slot_next = later.idx;
            end
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (advance) begin
            out_valid_next = cur_valid_reg;
            out_char_next  = tok_char(tok_cur, idx_reg, cur_job_reg);
            last_next      = job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        slot_reg     <= slot_next;
        idx_reg      <= idx_next;
        rep_reg      <= rep_next;
        cnt_reg      <= cnt_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign q_pop     = load;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> tok_cur != TOK_NONE) else $error("walking an empty slot");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg < len) else $error("token index past token end");
    a_rep_live: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && slot_reg == SlotW'(SlotBody) |-> rep_reg != '0)
        else $error("body repeat count exhausted");

endmodule

`default_nettype wire

>>> dv/text_to_html_escaper_unit_test.sv
// Testbench for text_to_html_escaper_unit: drives text items and register writes,
// predicts the HTML byte stream in a scoreboard class and checks every output item.
// Depends on tthe_pkg and the RTL of text_to_html_escaper_unit.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] ch;
    logic       fin;
} html_byte_t;

class escape_checker;
    localparam int TabStop = tthe_pkg::TabStopDefault;

    bit cvt_spaces, keep_high, use_question, quote_pfx, nl_break, pre_wrap;
    int col;
    bit line_fresh, space_held, pre_tag_live;
    logic [7:0] step_out[$];
    html_byte_t html_due[$];
    int errors;

    function new();
        cvt_spaces   = 0;
        keep_high    = 0;
        use_question = 0;
        quote_pfx    = 0;
        nl_break     = 0;
        pre_wrap     = 0;
        col          = 0;
        line_fresh   = 1;
        space_held   = 0;
        pre_tag_live = 0;
        errors       = 0;
    endfunction

    function void write_reg(tthe_pkg::cfg_idx_t idx, bit v);
        case (idx)
            tthe_pkg::CFG_CONVERT_SPACES:      cvt_spaces   = v;
            tthe_pkg::CFG_PRESERVE_HIGH_BYTES: keep_high    = v;
            tthe_pkg::CFG_QUESTION_HIGH_BYTES: use_question = v;
            tthe_pkg::CFG_QUOTE_PREFIX:        quote_pfx    = v;
            tthe_pkg::CFG_NEWLINE_BREAK:       nl_break     = v;
            tthe_pkg::CFG_WRAP_PRE:            pre_wrap     = v;
            default: ;
        endcase
    endfunction

    function int outstanding();
        return html_due.size();
    endfunction

    function void put(logic [7:0] c);
        if (step_out.size() < tthe_pkg::MaxResults)
            step_out.push_back(c);
    endfunction

    function void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function void next_col();
        col = (col + 1) % TabStop;
    endfunction

    // A held space takes its form from the byte that follows it.
    function void settle(bit as_nbsp);
        if (space_held)
        begin
            if (as_nbsp)
                put_str("&nbsp;");
            else
                put(8'h20);
            next_col();
            space_held = 0;
        end
    endfunction

    function void open_line();
        if (line_fresh)
        begin
            col = 0;
            if (quote_pfx)
            begin
                put_str("&gt; ");
                col = 2 % TabStop;
            end
            line_fresh = 0;
        end
    endfunction

    function void note_text_item(logic [7:0] u, logic fl);
        bit fresh_line;
        int v;
        step_out.delete();
        v = u;
        if (pre_wrap && !pre_tag_live)
        begin
            put_str("<pre>");
            pre_tag_live = 1;
        end
        if (fl)
        begin
            settle(0);
            if (pre_tag_live)
                put_str("</pre>");
            col          = 0;
            line_fresh   = 1;
            space_held   = 0;
            pre_tag_live = 0;
        end
        else if (u == 8'h0A)
        begin
            settle(0);
            open_line();
            if (nl_break)
                put_str("<br>");
            put(8'h0A);
            col        = 0;
            line_fresh = 1;
        end
        else
        begin
            fresh_line = line_fresh;
            open_line();
            settle(u == 8'h20 || u == 8'h09);
            if (u == "<")
            begin
                put_str("&lt;");
                next_col();
            end
            else if (u == ">")
            begin
                put_str("&gt;");
                next_col();
            end
            else if (u == "&")
            begin
                put_str("&amp;");
                next_col();
            end
            else if (u == "\"")
            begin
                put_str("&quot;");
                next_col();
            end
            else if (u == 8'h09 && cvt_spaces)
            begin
                do
                begin
                    put_str("&nbsp;");
                    next_col();
                end
                while (col != 0);
            end
            else if (u == 8'h20 && cvt_spaces)
            begin
                if (fresh_line)
                begin
                    put_str("&nbsp;");
                    next_col();
                end
                else
                    space_held = 1;
            end
            else
            begin
                if ((u < 8'h20 || u >= 8'h80) && !keep_high)
                begin
                    if (use_question)
                        put("?");
                    else
                    begin
                        put_str("&#");
                        if (v >= 100)
                            put(8'h30 + 8'(v / 100));
                        if (v >= 10)
                            put(8'h30 + 8'((v / 10) % 10));
                        put(8'h30 + 8'(v % 10));
                        put(";");
                    end
                end
                else
                    put(u);
                next_col();
            end
        end
        foreach (step_out[i])
            html_due.push_back('{ch: step_out[i], fin: (i == step_out.size() - 1)});
    endfunction

    function void check_html_byte(logic [7:0] ch, logic fin);
        html_byte_t want;
        if (html_due.size() == 0)
        begin
            $error("out_char: expected none, got %02h", ch);
            errors++;
            return;
        end
        want = html_due.pop_front();
        if (ch !== want.ch)
        begin
            $error("out_char: expected %02h, got %02h", want.ch, ch);
            errors++;
        end
        if (fin !== want.fin)
        begin
            $error("last: expected %0b, got %0b", want.fin, fin);
            errors++;
        end
    endfunction
endclass

module text_to_html_escaper_unit_test;
    import tthe_pkg::*;

    localparam int SettleCycles  = 16;
    localparam int CycleLimit    = 500000;
    localparam int NumPhases     = 9;
    localparam int ItemsPerPhase = 26;
    localparam logic [7:0] SampleText [0:21] = '{
        8'h20, "a", 8'h20, 8'h20, 8'h09, "x", 8'h20, "<", ">", "&", "\"",
        8'h00, 8'h7F, 8'h80, 8'hFF, 8'h1F, 8'h20, 8'h0A, 8'h0A, 8'h09, "b", 8'h20
    };

    typedef enum int { FLOW_FREE, FLOW_LIGHT, FLOW_PERIODIC, FLOW_HEAVY } flow_pattern_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       flush;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic       last;

    escape_checker html_sb;
    int            cycle_count;
    int            burst_left;
    int            gap_left;
    flow_pattern_t flow;
    int            flow_left;
    int            flow_tick;

    text_to_html_escaper_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .flush     (flush),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                html_sb.check_html_byte(out_char, last);
            if (in_valid && !in_stall)
                html_sb.note_text_item(text_byte, flush);
        end
    end

    // Receiver: switch between free flow, light, periodic and heavy stalling.
    initial
    begin
        out_stall = 0;
        flow_left = 0;
        flow_tick = 0;
        forever
        begin
            @(negedge clk);
            if (flow_left == 0)
            begin
                flow      = flow_pattern_t'($urandom_range(0, 3));
                flow_left = $urandom_range(16, 96);
            end
            flow_left--;
            flow_tick++;
            case (flow)
                FLOW_FREE:     out_stall = 0;
                FLOW_LIGHT:    out_stall = ($urandom_range(0, 9) < 3);
                FLOW_PERIODIC: out_stall = (flow_tick % 3 == 0);
                default:       out_stall = ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    task automatic write_one(input cfg_idx_t idx, input logic v);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = v;
        html_sb.write_reg(idx, v);
    endtask

    task automatic write_settings(input cfg_t s);
        write_one(CFG_CONVERT_SPACES, s.convert_spaces);
        write_one(CFG_PRESERVE_HIGH_BYTES, s.preserve_high_bytes);
        write_one(CFG_QUESTION_HIGH_BYTES, s.question_high_bytes);
        write_one(CFG_QUOTE_PREFIX, s.quote_prefix);
        write_one(CFG_NEWLINE_BREAK, s.newline_break);
        write_one(CFG_WRAP_PRE, s.wrap_pre);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic send_text_item(input logic [7:0] b, input logic fl);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        while (gap_left > 0)
        begin
            @(negedge clk);
            in_valid  = 0;
            text_byte = 8'($urandom_range(0, 255));
            gap_left--;
        end
        @(negedge clk);
        in_valid  = 1;
        text_byte = b;
        flush     = fl;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
    endtask

    // Hold input until every predicted byte is out; optionally keep input idle for the settle period too.
    task automatic wait_drained(input bit settle);
        @(negedge clk);
        in_valid = 0;
        while (html_sb.outstanding() > 0)
            @(posedge clk);
        if (settle)
            repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic send_random_text();
        int r;
        logic [7:0] b;
        logic fl;
        r  = $urandom_range(0, 99);
        fl = 0;
        if (r < 3)
        begin
            fl = 1;
            b  = 8'($urandom_range(0, 255));
        end
        else if (r < 17)
            b = 8'h20;
        else if (r < 22)
            b = 8'h09;
        else if (r < 29)
            b = 8'h0A;
        else if (r < 38)
        begin
            case ($urandom_range(0, 3))
                0:       b = "<";
                1:       b = ">";
                2:       b = "&";
                default: b = "\"";
            endcase
        end
        else if (r < 47)
            b = 8'($urandom_range(0, 255));
        else
            b = 8'($urandom_range(8'h21, 8'h7E));
        send_text_item(b, fl);
    endtask

    initial
    begin
        cfg_t demo_cfg;
        html_sb     = new();
        cycle_count = 0;
        burst_left  = 0;
        gap_left    = 0;
        cfg_we      = 0;
        cfg_index   = CFG_CONVERT_SPACES;
        cfg_data    = 0;
        in_valid    = 0;
        text_byte   = 0;
        flush       = 0;
        rst_n       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        demo_cfg                     = '0;
        demo_cfg.convert_spaces      = 1;
        demo_cfg.quote_prefix        = 1;
        demo_cfg.newline_break       = 1;
        demo_cfg.wrap_pre            = 1;
        write_settings(demo_cfg);
        foreach (SampleText[i])
            send_text_item(SampleText[i], 0);
        send_text_item(8'hA5, 1);
        send_text_item(8'h5A, 1);
        wait_drained(1);

        for (int p = 0; p < NumPhases; p++)
        begin
            if (p == 0)
                write_settings('0);
            else if (p == 1)
                write_settings('1);
            else
                write_settings(cfg_t'(6'($urandom_range(0, 63))));
            for (int i = 0; i < ItemsPerPhase; i++)
            begin
                send_random_text();
                if ($urandom_range(0, 49) == 0)
                    wait_drained(0);
            end
            wait_drained(1);
        end

        wait_drained(1);
        if (html_sb.errors == 0 && html_sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
